// ----- rtl/core/counter_based_weight_init_generator_defines.svh -----
// Assertion macros for the weight initialisation generator.
// Used by the top level only; no other dependencies.
`ifndef COUNTER_BASED_WEIGHT_INIT_GENERATOR_DEFINES_SVH
`define COUNTER_BASED_WEIGHT_INIT_GENERATOR_DEFINES_SVH

// Checked on every rising edge of clk_i, quiet while rst_ni is low.
`define CBWIG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CBWIG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/cbwig_pkg.sv -----
// Shared types and constants for the weight initialisation generator.
// No dependencies.
`default_nettype none
package cbwig_pkg;

  localparam logic [63:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;
  localparam logic [8:0]  FnvPrimeLow = 9'h1B3;  // prime is 2^40 + 0x1b3
  localparam logic [63:0] SmGamma = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SmMul1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SmMul2 = 64'h94D0_49BB_1331_11EB;
  localparam logic [24:0] HalfQ23 = 25'd8388608;

  localparam logic SeedIdx  = 1'b0;
  localparam logic BoundIdx = 1'b1;
  localparam logic [63:0] SeedReset  = 64'd42;
  localparam logic [23:0] BoundReset = 24'd10273801;

  typedef enum logic [1:0] {
    MODE_KEY_RESET = 2'd0,
    MODE_ABSORB    = 2'd1,
    MODE_SAMPLE    = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_IDX,
    PH_FIN
  } phase_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_RESET,
    OP_KEY_ABSORB,
    OP_CAPTURE,
    OP_LOAD,
    OP_GAMMA,
    OP_XS30,
    OP_XS27,
    OP_MUL_LL,
    OP_MUL_HL,
    OP_MUL_LH,
    OP_STORE,
    OP_WEIGHT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_GAMMA,
    S_XS30,
    S_MLL,
    S_MHL,
    S_MLH,
    S_XS27,
    S_STORE,
    S_WEIGHT
  } state_e;

  typedef struct packed {
    op_e    op;
    phase_e phase;
    logic   mul2;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/cbwig_ctrl.sv -----
// Sequencer for the weight initialisation generator: steps the datapath
// through three mixes and the weight product. Uses cbwig_pkg.
`default_nettype none
module cbwig_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     mode_i,
  output logic                in_ready_o,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output cbwig_pkg::cmd_t     cmd_o
);

  cbwig_pkg::state_e state_q, state_d;
  cbwig_pkg::phase_e phase_q, phase_d;
  logic mul2_q, mul2_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbwig_pkg::S_IDLE;
      phase_q     <= cbwig_pkg::PH_KEY;
      mul2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      mul2_q      <= mul2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    mul2_d      = mul2_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = cbwig_pkg::OP_NONE;
    cmd_o.phase = phase_q;
    cmd_o.mul2  = mul2_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      cbwig_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (cbwig_pkg::mode_e'(mode_i))
            cbwig_pkg::MODE_KEY_RESET: cmd_o.op = cbwig_pkg::OP_KEY_RESET;
            cbwig_pkg::MODE_ABSORB:    cmd_o.op = cbwig_pkg::OP_KEY_ABSORB;
            cbwig_pkg::MODE_SAMPLE: begin
              cmd_o.op = cbwig_pkg::OP_CAPTURE;
              phase_d  = cbwig_pkg::PH_KEY;
              state_d  = cbwig_pkg::S_LOAD;
            end
            default: cmd_o.op = cbwig_pkg::OP_NONE;
          endcase
        end
      end
      cbwig_pkg::S_LOAD: begin
        cmd_o.op = cbwig_pkg::OP_LOAD;
        state_d  = cbwig_pkg::S_GAMMA;
      end
      cbwig_pkg::S_GAMMA: begin
        cmd_o.op = cbwig_pkg::OP_GAMMA;
        state_d  = cbwig_pkg::S_XS30;
      end
      cbwig_pkg::S_XS30: begin
        cmd_o.op = cbwig_pkg::OP_XS30;
        mul2_d   = 1'b0;
        state_d  = cbwig_pkg::S_MLL;
      end
      cbwig_pkg::S_MLL: begin
        cmd_o.op = cbwig_pkg::OP_MUL_LL;
        state_d  = cbwig_pkg::S_MHL;
      end
      cbwig_pkg::S_MHL: begin
        cmd_o.op = cbwig_pkg::OP_MUL_HL;
        state_d  = cbwig_pkg::S_MLH;
      end
      cbwig_pkg::S_MLH: begin
        cmd_o.op = cbwig_pkg::OP_MUL_LH;
        state_d  = mul2_q ? cbwig_pkg::S_STORE : cbwig_pkg::S_XS27;
      end
      cbwig_pkg::S_XS27: begin
        cmd_o.op = cbwig_pkg::OP_XS27;
        mul2_d   = 1'b1;
        state_d  = cbwig_pkg::S_MLL;
      end
      cbwig_pkg::S_STORE: begin
        cmd_o.op = cbwig_pkg::OP_STORE;
        unique case (phase_q)
          cbwig_pkg::PH_KEY: begin
            phase_d = cbwig_pkg::PH_IDX;
            state_d = cbwig_pkg::S_LOAD;
          end
          cbwig_pkg::PH_IDX: begin
            phase_d = cbwig_pkg::PH_FIN;
            state_d = cbwig_pkg::S_LOAD;
          end
          default: state_d = cbwig_pkg::S_WEIGHT;
        endcase
      end
      cbwig_pkg::S_WEIGHT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = cbwig_pkg::OP_WEIGHT;
          out_valid_d = 1'b1;
          state_d     = cbwig_pkg::S_IDLE;
        end
      end
      default: state_d = cbwig_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/cbwig_datapath.sv -----
// Datapath of the weight initialisation generator: key hash, config
// registers, shared 32x32 multiplier and weight product. Uses cbwig_pkg.
`default_nettype none
module cbwig_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cbwig_pkg::cmd_t    cmd_i,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [63:0]        cfg_wdata_i,
  input  wire logic [7:0]         name_byte_i,
  input  wire logic [63:0]        sample_index_i,
  output logic [23:0]             uniform_bits_o,
  output logic signed [24:0]      weight_value_o
);

  logic [63:0] seed_q;
  logic [23:0] bound_q;
  logic [63:0] key_q;
  logic [63:0] idx_q, hk_q, hi_q;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q;
  logic [23:0] u_q;
  logic [23:0] uo_q;
  logic signed [24:0] wo_q;

  // FNV step: (k ^ b) * (2^40 + 0x1b3)
  logic [63:0] fnv_x, fnv_next;
  logic [72:0] fnv_lo;
  assign fnv_x    = key_q ^ {56'd0, name_byte_i};
  assign fnv_lo   = fnv_x * cbwig_pkg::FnvPrimeLow;
  assign fnv_next = {fnv_x[23:0], 40'd0} + fnv_lo[63:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= cbwig_pkg::SeedReset;
      bound_q <= cbwig_pkg::BoundReset;
      key_q   <= cbwig_pkg::FnvBasis;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cbwig_pkg::SeedIdx:  seed_q  <= cfg_wdata_i;
          cbwig_pkg::BoundIdx: bound_q <= cfg_wdata_i[23:0];
          default: ;
        endcase
      end
      if (cmd_i.op == cbwig_pkg::OP_KEY_RESET) key_q <= cbwig_pkg::FnvBasis;
      else if (cmd_i.op == cbwig_pkg::OP_KEY_ABSORB) key_q <= fnv_next;
    end
  end

  // shared multiplier, one 32x32 partial product a cycle
  logic [63:0] mconst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] rmix;
  assign mconst = cmd_i.mul2 ? cbwig_pkg::SmMul2 : cbwig_pkg::SmMul1;
  assign mul_a  = (cmd_i.op == cbwig_pkg::OP_MUL_HL) ? x_q[63:32] : x_q[31:0];
  assign mul_b  = (cmd_i.op == cbwig_pkg::OP_MUL_LH) ? mconst[63:32] : mconst[31:0];
  assign mul_p  = mul_a * mul_b;
  assign rmix   = x_q ^ (x_q >> 31);

  always_comb begin
    x_d = x_q;
    unique case (cmd_i.op)
      cbwig_pkg::OP_LOAD: begin
        unique case (cmd_i.phase)
          cbwig_pkg::PH_KEY: x_d = key_q;
          cbwig_pkg::PH_IDX: x_d = idx_q;
          default:           x_d = seed_q ^ hk_q ^ hi_q;
        endcase
      end
      cbwig_pkg::OP_GAMMA:  x_d = x_q + cbwig_pkg::SmGamma;
      cbwig_pkg::OP_XS30:   x_d = x_q ^ (x_q >> 30);
      cbwig_pkg::OP_XS27:   x_d = x_q ^ (x_q >> 27);
      cbwig_pkg::OP_MUL_LH: x_d = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
      default:              x_d = x_q;
    endcase
  end

  // weight = floor((u - 2^23) * bound / 2^23)
  logic signed [24:0] dev, bnd;
  logic signed [49:0] prod;
  assign dev  = $signed({1'b0, u_q}) - $signed(cbwig_pkg::HalfQ23);
  assign bnd  = $signed({1'b0, bound_q});
  assign prod = dev * bnd;

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (cmd_i.op == cbwig_pkg::OP_CAPTURE) idx_q <= sample_index_i;
    if (cmd_i.op == cbwig_pkg::OP_MUL_LL) acc_q <= mul_p;
    if (cmd_i.op == cbwig_pkg::OP_MUL_HL) acc_q[63:32] <= acc_q[63:32] + mul_p[31:0];
    if (cmd_i.op == cbwig_pkg::OP_STORE) begin
      unique case (cmd_i.phase)
        cbwig_pkg::PH_KEY: hk_q <= rmix;
        cbwig_pkg::PH_IDX: hi_q <= rmix;
        default:           u_q  <= rmix[63:40];
      endcase
    end
    if (cmd_i.op == cbwig_pkg::OP_WEIGHT) begin
      uo_q <= u_q;
      wo_q <= prod[47:23];
    end
  end

  assign uniform_bits_o = uo_q;
  assign weight_value_o = wo_q;

endmodule
`default_nettype wire

// ----- rtl/core/counter_based_weight_init_generator.sv -----
// Top level of the counter-based weight initialisation generator.
// Depends on cbwig_pkg, cbwig_ctrl, cbwig_datapath and the defines header.
//
// A name-reset or name-byte request completes when accepted: in_ready_o
// stays high. A sample request runs three splitmix64 passes and then the
// weight step; each pass runs its two 64-bit constant multiplies as three
// 32x32 partial products on one shared multiplier. No new request is
// accepted until the weight step is done. The result sits in an output
// register, so the next request is accepted as soon as the sequencer is
// idle, even while the result waits; a following sample stalls only at its
// final step if the earlier result has still not been taken.
// Configuration writes take effect at once.
`default_nettype none
`include "counter_based_weight_init_generator_defines.svh"
module counter_based_weight_init_generator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [63:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [7:0]         name_byte_i,
  input  wire logic [63:0]        sample_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [23:0]             uniform_bits_o,
  output logic signed [24:0]      weight_value_o
);

  cbwig_pkg::cmd_t cmd;

  cbwig_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  cbwig_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .name_byte_i    (name_byte_i),
    .sample_index_i (sample_index_i),
    .uniform_bits_o (uniform_bits_o),
    .weight_value_o (weight_value_o)
  );

  `CBWIG_ASSERT(a_busy_after_sample, (in_valid_i && in_ready_o && mode_i == cbwig_pkg::MODE_SAMPLE) |=> !in_ready_o, "sequencer not busy after sample request")
  `CBWIG_ASSERT(a_capture_on_sample, (in_valid_i && in_ready_o && mode_i == cbwig_pkg::MODE_SAMPLE) |-> (cmd.op == cbwig_pkg::OP_CAPTURE), "sample index not captured")
  `CBWIG_ASSERT(a_result_from_weight, $rose(out_valid_o) |-> $past(cmd.op == cbwig_pkg::OP_WEIGHT), "result raised without weight step")
  `CBWIG_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_o && in_ready_o), "outputs active in reset")

endmodule
`default_nettype wire
